>>> src/laser_spot_difference_peak_height_macros.svh
// Assertion macros shared by the laser spot difference peak height RTL.
// Every user must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef LASER_SPOT_DIFFERENCE_PEAK_HEIGHT_MACROS_SVH
`define LASER_SPOT_DIFFERENCE_PEAK_HEIGHT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LSDPH_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Property whose consequence must hold in the cycle after its trigger.
`define LSDPH_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

>>> src/lsdph_pkg.sv
// Package for the laser spot difference peak height block: widths, reset values,
// register codes, payload structs and the back-end state type. No dependencies.
package lsdph_pkg;

    // Sizes fixed by the field widths.
    localparam int FRAME_PIXELS_DEF = 1024;
    localparam int PIXEL_BITS       = 12;
    localparam int CNT_W            = 7;
    localparam int SENS_W           = 8;
    localparam int LIN_W            = 14;
    localparam int WORD_W           = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int QUEUE_DEPTH      = 8;
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int DIF_W            = SENS_W + 1;
    localparam int PROD_W           = DIF_W + WORD_W;
    localparam int DEN_W            = PROD_W + 1;
    localparam int FRAC_W           = 16;
    localparam int DVD_W            = WORD_W + FRAC_W;

    // Register reset values.
    localparam logic [CNT_W-1:0]  ROW_START_RST = 7'd21;
    localparam logic [CNT_W-1:0]  ROW_COUNT_RST = 7'd90;
    localparam logic [CNT_W-1:0]  COL_START_RST = 7'd50;
    localparam logic [CNT_W-1:0]  COL_COUNT_RST = 7'd11;
    localparam logic [SENS_W-1:0] OPT_ROW_RST   = 8'd56;

    // Saturation limits of the height.
    localparam logic signed [WORD_W-1:0] HEIGHT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] HEIGHT_MIN = 32'sh8000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_START,
        CFG_ROW_COUNT,
        CFG_COL_START,
        CFG_COL_COUNT,
        CFG_OPT_ROW,
        CFG_TAN_ALPHA,
        CFG_X_TERM,
        CFG_NUMERATOR
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]         row_start;
        logic [CNT_W-1:0]         row_count;
        logic [CNT_W-1:0]         col_start;
        logic [CNT_W-1:0]         col_count;
        logic [SENS_W-1:0]        optical_center_row;
        logic signed [WORD_W-1:0] tan_alpha;
        logic signed [WORD_W-1:0] x_term;
        logic signed [WORD_W-1:0] height_numerator;
    } t_cfg;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_value;
        logic                  first_of_pair;
    } t_pixel_in;

    typedef struct packed {
        logic [PIXEL_BITS-1:0]    diff_value;
        logic [SENS_W-1:0]        peak_row;
        logic [SENS_W-1:0]        peak_col;
        logic [PIXEL_BITS-1:0]    peak_value;
        logic signed [WORD_W-1:0] height;
        logic                     pair_done;
    } t_result;

    // One front-end pipeline stage.
    typedef struct packed {
        logic                  wr;
        logic [LIN_W-1:0]      lin;
        logic [PIXEL_BITS-1:0] pix;
        logic [SENS_W-1:0]     srow;
        logic [SENS_W-1:0]     scol;
        logic                  fresh;
        logic                  last;
    } t_fstage;

    // One laser-on pixel waiting for the back end.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] old_pix;
        logic [PIXEL_BITS-1:0] new_pix;
        logic [SENS_W-1:0]     srow;
        logic [SENS_W-1:0]     scol;
        logic                  fresh;
        logic                  last;
    } t_qitem;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_ctrl;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_stat;

    typedef enum logic [2:0] {
        BK_RUN,
        BK_MUL,
        BK_SUM,
        BK_START,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

>>> src/lsdph_queue.sv
// Short FIFO of laser-on transactions between the front and back ends.
// Depends on lsdph_pkg and the assertion macro header.
`include "laser_spot_difference_peak_height_macros.svh"

module lsdph_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lsdph_pkg::t_qitem i_item,
    input  logic              i_pop,
    output logic              o_valid,
    output lsdph_pkg::t_qitem o_item,
    output logic [lsdph_pkg::QCNT_W-1:0] o_count
);
    import lsdph_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_qitem             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]  r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_slot[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

    `LSDPH_ASSERT(a_no_overflow, i_push |-> (r_count != QCNT_W'(QUEUE_DEPTH)), "queue overflow")
    `LSDPH_ASSERT(a_no_underflow, i_pop |-> (r_count != '0), "queue underflow")

endmodule

>>> src/lsdph_front.sv
// Front end: takes pixels, walks the window counters, maps each pixel to a store
// address and writes or reads the frame store. Depends on lsdph_pkg and macros.
`include "laser_spot_difference_peak_height_macros.svh"

module lsdph_front #(
    parameter int FRAME_PIXELS = lsdph_pkg::FRAME_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  lsdph_pkg::t_pixel_in            i_pixel,
    input  lsdph_pkg::t_cfg                 i_cfg,
    input  logic [lsdph_pkg::QCNT_W-1:0]    i_q_count,
    output logic                            o_push,
    output lsdph_pkg::t_qitem               o_item
);
    import lsdph_pkg::*;

    localparam int ADDR_W  = $clog2(FRAME_PIXELS);
    localparam int SH      = 2 * LIN_W;
    localparam int RECIP_W = SH + 1 - $clog2(FRAME_PIXELS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SH) / FRAME_PIXELS);
    localparam logic [LIN_W:0]     FP_L  = (LIN_W + 1)'(FRAME_PIXELS);
    localparam int FILL_W  = QCNT_W + 1;

    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] r_col;
    logic             r_second;
    logic             r_fresh;

    logic             r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    t_fstage          r_s1, r_s2, r_s3, r_s4;
    logic [LIN_W-1:0] r_s2_q;
    logic [ADDR_W-1:0] r_s3_addr;
    logic [PIXEL_BITS-1:0] r_s4_old;
    logic [PIXEL_BITS-1:0] r_store [FRAME_PIXELS];

    logic             acc;
    logic             fop;
    logic [CNT_W-1:0] row_e, col_e, rows, cols;
    logic             sec_e, fresh_e;
    logic             row_end, frame_end;
    logic [LIN_W-1:0] lin;
    logic [LIN_W+RECIP_W-1:0] recip_prod;
    logic [LIN_W-1:0] q_times_fp;
    logic [LIN_W:0]   rem;
    logic [LIN_W:0]   rem_fix;
    logic [2:0]       inflight;
    logic [FILL_W-1:0] fill;

    // Credit check: accept only if every transaction in flight still fits the queue.
    assign inflight = 3'(r_s1_v) + 3'(r_s2_v) + 3'(r_s3_v) + 3'(r_s4_v);
    assign fill     = FILL_W'(i_q_count) + FILL_W'(inflight);
    assign o_ready  = (fill < FILL_W'(QUEUE_DEPTH));
    assign acc      = i_valid && o_ready;

    // Effective walk state, with the restart mark applied.
    assign fop     = i_pixel.first_of_pair;
    assign row_e   = fop ? '0 : r_row;
    assign col_e   = fop ? '0 : r_col;
    assign sec_e   = fop ? 1'b0 : r_second;
    assign fresh_e = fop ? 1'b1 : r_fresh;
    assign rows    = (i_cfg.row_count == '0) ? CNT_W'(1) : i_cfg.row_count;
    assign cols    = (i_cfg.col_count == '0) ? CNT_W'(1) : i_cfg.col_count;
    assign row_end   = ({1'b0, col_e} + (CNT_W + 1)'(1)) >= {1'b0, cols};
    assign frame_end = row_end && (({1'b0, row_e} + (CNT_W + 1)'(1)) >= {1'b0, rows});
    assign lin = LIN_W'(LIN_W'(row_e) * LIN_W'(cols)) + LIN_W'(col_e);

    // Window counters and frame phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_second <= 1'b0;
            r_fresh  <= 1'b1;
        end else if (acc) begin
            if (frame_end) begin
                r_row    <= '0;
                r_col    <= '0;
                r_second <= !sec_e;
                r_fresh  <= 1'b1;
            end else begin
                r_second <= sec_e;
                r_fresh  <= fresh_e && !sec_e;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= row_e + CNT_W'(1);
                end else begin
                    r_col <= col_e + CNT_W'(1);
                    r_row <= row_e;
                end
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= acc;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    // Address arithmetic: linear index, then reduction modulo the store depth
    // by a reciprocal multiply with one corrective subtract.
    assign recip_prod = (LIN_W + RECIP_W)'(r_s1.lin) * (LIN_W + RECIP_W)'(RECIP);
    assign q_times_fp = LIN_W'(r_s2_q * FP_L);
    assign rem        = {1'b0, r_s2.lin} - {1'b0, q_times_fp};
    assign rem_fix    = (rem >= FP_L) ? (rem - FP_L) : rem;

    always_ff @(posedge i_clk) begin
        r_s1.wr    <= !sec_e;
        r_s1.lin   <= lin;
        r_s1.pix   <= i_pixel.pixel_value;
        r_s1.srow  <= SENS_W'(row_e) + SENS_W'(i_cfg.row_start);
        r_s1.scol  <= SENS_W'(col_e) + SENS_W'(i_cfg.col_start);
        r_s1.fresh <= fresh_e;
        r_s1.last  <= frame_end;
        r_s2       <= r_s1;
        r_s2_q     <= LIN_W'(recip_prod >> SH);
        r_s3       <= r_s2;
        r_s3_addr  <= ADDR_W'(rem_fix);
        r_s4       <= r_s3;
    end

    // Frame store: laser-off pixels are written, laser-on pixels read back.
    always_ff @(posedge i_clk) begin
        if (r_s3_v) begin
            if (r_s3.wr) begin
                r_store[r_s3_addr] <= r_s3.pix;
            end else begin
                r_s4_old <= r_store[r_s3_addr];
            end
        end
    end

    // Hand laser-on transactions to the queue.
    assign o_push         = r_s4_v && !r_s4.wr;
    assign o_item.old_pix = r_s4_old;
    assign o_item.new_pix = r_s4.pix;
    assign o_item.srow    = r_s4.srow;
    assign o_item.scol    = r_s4.scol;
    assign o_item.fresh   = r_s4.fresh;
    assign o_item.last    = r_s4.last;

    `LSDPH_ASSERT_NEXT(a_restart_clears, acc && fop, r_fresh, "restart did not clear the tracker")

endmodule

>>> src/lsdph_div.sv
// Restoring divider, one quotient bit per cycle, on unsigned magnitudes.
// Depends on lsdph_pkg and the assertion macro header.
`include "laser_spot_difference_peak_height_macros.svh"

module lsdph_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsdph_pkg::t_div_ctrl i_ctrl,
    output lsdph_pkg::t_div_stat o_stat
);
    import lsdph_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DEN_W-1:0]  r_dvs;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              ge;

    // One trial subtraction per cycle.
    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // Sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills with quotient bits from the right.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_dvd <= i_ctrl.dividend;
            r_dvs <= i_ctrl.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_dvd;

    `LSDPH_ASSERT_NEXT(a_start_busy, i_ctrl.start, r_busy, "divider did not start")

endmodule

>>> src/lsdph_back.sv
// Back end: absolute difference, peak tracking and the height computation at
// the end of each pair. Depends on lsdph_pkg, lsdph_div and the macro header.
`include "laser_spot_difference_peak_height_macros.svh"

module lsdph_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsdph_pkg::t_cfg      i_cfg,
    input  logic                 i_q_valid,
    input  lsdph_pkg::t_qitem    i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lsdph_pkg::t_result   o_result
);
    import lsdph_pkg::*;

    t_back_state r_state, n_state;

    logic [PIXEL_BITS-1:0]    r_best_val;
    logic [SENS_W-1:0]        r_best_row;
    logic [SENS_W-1:0]        r_best_col;
    logic [PIXEL_BITS-1:0]    r_last_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DEN_W-1:0]  r_den;
    logic                     r_num_neg;
    logic signed [WORD_W-1:0] r_height;
    logic                     r_out_valid;
    t_result                  r_out;

    logic                     out_free;
    logic                     pop;
    logic                     div_start;
    logic [PIXEL_BITS-1:0]    diff;
    logic                     take_best;
    logic signed [DIF_W-1:0]  row_dif;
    logic [WORD_W-1:0]        num_mag;
    logic [DEN_W-1:0]         den_mag;
    logic                     q_neg;
    logic [DVD_W-1:0]         quo;
    logic signed [WORD_W-1:0] height_c;
    t_div_ctrl                div_ctrl;
    t_div_stat                div_stat;

    assign out_free = !r_out_valid || i_ready;

    // Difference and peak comparison; ties keep the earlier pixel.
    assign diff      = (i_item.old_pix > i_item.new_pix) ? (i_item.old_pix - i_item.new_pix)
                                                         : (i_item.new_pix - i_item.old_pix);
    assign take_best = i_item.fresh || (diff > r_best_val);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_RUN: begin
                if (pop && i_item.last) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL:   n_state = BK_SUM;
            BK_SUM:   n_state = BK_START;
            BK_START: n_state = BK_DIV;
            BK_DIV: begin
                if (div_stat.done) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_state = BK_RUN;
                end
            end
            default:  n_state = BK_RUN;
        endcase
    end

    // State outputs.
    always_comb begin
        pop       = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            BK_RUN:   pop = i_q_valid && out_free;
            BK_START: div_start = 1'b1;
            default: begin
                pop       = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider operands: magnitudes of the scaled numerator and the divisor.
    assign row_dif = $signed({1'b0, i_cfg.optical_center_row} - {1'b0, r_best_row});
    assign num_mag = i_cfg.height_numerator[WORD_W-1] ? (~i_cfg.height_numerator + WORD_W'(1))
                                                      : i_cfg.height_numerator;
    assign den_mag = r_den[DEN_W-1] ? (~r_den + DEN_W'(1)) : r_den;

    assign div_ctrl.start    = div_start;
    assign div_ctrl.dividend = {num_mag, {FRAC_W{1'b0}}};
    assign div_ctrl.divisor  = den_mag;

    lsdph_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .o_stat  (div_stat)
    );

    // Sign and saturation of the quotient; a zero divisor saturates by numerator sign.
    assign quo   = div_stat.quotient;
    assign q_neg = r_num_neg ^ r_den[DEN_W-1];
    always_comb begin
        if (r_den == '0) begin
            height_c = r_num_neg ? HEIGHT_MIN : HEIGHT_MAX;
        end else if (q_neg) begin
            if (quo > DVD_W'(64'h8000_0000)) begin
                height_c = HEIGHT_MIN;
            end else begin
                height_c = $signed(~quo[WORD_W-1:0] + WORD_W'(1));
            end
        end else begin
            if (quo > DVD_W'(64'h7FFF_FFFF)) begin
                height_c = HEIGHT_MAX;
            end else begin
                height_c = $signed(quo[WORD_W-1:0]);
            end
        end
    end

    // Peak tracker and height datapath.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (take_best) begin
                r_best_val <= diff;
                r_best_row <= i_item.srow;
                r_best_col <= i_item.scol;
            end
            if (i_item.last) begin
                r_last_diff <= diff;
            end
        end
        if (r_state == BK_MUL) begin
            r_prod    <= PROD_W'(row_dif) * PROD_W'(i_cfg.tan_alpha);
            r_num_neg <= i_cfg.height_numerator[WORD_W-1];
        end
        if (r_state == BK_SUM) begin
            r_den <= DEN_W'(r_prod) + DEN_W'(i_cfg.x_term);
        end
        if (r_state == BK_DIV && div_stat.done) begin
            r_height <= height_c;
        end
    end

    // Output register: per-pixel difference, or the full pair result.
    always_ff @(posedge i_clk) begin
        if (pop && !i_item.last) begin
            r_out.diff_value <= diff;
            r_out.peak_row   <= '0;
            r_out.peak_col   <= '0;
            r_out.peak_value <= '0;
            r_out.height     <= '0;
            r_out.pair_done  <= 1'b0;
        end else if (r_state == BK_EMIT && out_free) begin
            r_out.diff_value <= r_last_diff;
            r_out.peak_row   <= r_best_row;
            r_out.peak_col   <= r_best_col;
            r_out.peak_value <= r_best_val;
            r_out.height     <= r_height;
            r_out.pair_done  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((pop && !i_item.last) || (r_state == BK_EMIT && out_free)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pop    = pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `LSDPH_ASSERT_NEXT(a_div_to_emit, (r_state == BK_DIV) && div_stat.done, r_state == BK_EMIT, "missed divider completion")
    `LSDPH_ASSERT(a_emit_idle_div, (r_state == BK_EMIT) |-> !div_stat.busy, "result emitted while dividing")

endmodule

>>> src/laser_spot_difference_peak_height.sv
// Laser spot finder: a laser-on pixel's difference passes the front-end stages, the queue
// and the output register; the pair result waits mostly on the 48-step divider.
// One pixel per cycle is accepted while the queue has room, also during the division.
// Reset clears the walk counters, the frame phase, the queue and the registers to their
// defaults; the frame store is not cleared and no clearing pass is run.
// Depends on lsdph_pkg, lsdph_front, lsdph_queue and lsdph_back.
module laser_spot_difference_peak_height #(
    parameter int FRAME_PIXELS = lsdph_pkg::FRAME_PIXELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  lsdph_pkg::t_pixel_in                  i_pixel,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output lsdph_pkg::t_result                    o_result,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lsdph_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lsdph_pkg::WORD_W-1:0]          i_cfg_data
);
    import lsdph_pkg::*;

    t_cfg              r_cfg;
    logic              push;
    t_qitem            push_item;
    logic              pop;
    logic              q_valid;
    t_qitem            q_item;
    logic [QCNT_W-1:0] q_count;

    // Configuration registers; a write transaction is taken in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_start          <= ROW_START_RST;
            r_cfg.row_count          <= ROW_COUNT_RST;
            r_cfg.col_start          <= COL_START_RST;
            r_cfg.col_count          <= COL_COUNT_RST;
            r_cfg.optical_center_row <= OPT_ROW_RST;
            r_cfg.tan_alpha          <= '0;
            r_cfg.x_term             <= '0;
            r_cfg.height_numerator   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_START: r_cfg.row_start          <= i_cfg_data[CNT_W-1:0];
                CFG_ROW_COUNT: r_cfg.row_count          <= i_cfg_data[CNT_W-1:0];
                CFG_COL_START: r_cfg.col_start          <= i_cfg_data[CNT_W-1:0];
                CFG_COL_COUNT: r_cfg.col_count          <= i_cfg_data[CNT_W-1:0];
                CFG_OPT_ROW:   r_cfg.optical_center_row <= i_cfg_data[SENS_W-1:0];
                CFG_TAN_ALPHA: r_cfg.tan_alpha          <= $signed(i_cfg_data);
                CFG_X_TERM:    r_cfg.x_term             <= $signed(i_cfg_data);
                CFG_NUMERATOR: r_cfg.height_numerator   <= $signed(i_cfg_data);
            endcase
        end
    end

    lsdph_front #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_pixel   (i_pixel),
        .i_cfg     (r_cfg),
        .i_q_count (q_count),
        .o_push    (push),
        .o_item    (push_item)
    );

    lsdph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    lsdph_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );

endmodule

>>> bench/tb.sv
// Self-checking testbench for laser_spot_difference_peak_height: directed table, random windows.
// Depends on lsdph_pkg and the laser_spot_difference_peak_height RTL only.
`timescale 1ns / 100ps

module tb;
    import lsdph_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SMALL_ITEMS  = 250;
    localparam int STORE_DEPTH  = FRAME_PIXELS_DEF;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_pixel_in            i_pixel     = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    // One row of the directed table: a register write or a pixel transaction.
    typedef struct {
        bit            is_reg;
        t_cfg_idx      reg_idx;
        logic [31:0]   reg_data;
        t_pixel_in     px;
        bit            typed;
        t_result       want;
    } t_plan_row;

    t_plan_row directed_plan[$];
    t_result   spot_results_due[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    bit        no_idle = 1'b0;

    // Mirror of the registers and of the frame walk.
    t_cfg                  regs_mirror;
    logic [PIXEL_BITS-1:0] dark_frame [STORE_DEPTH];
    logic [CNT_W-1:0]      walk_row, walk_col;
    bit                    laser_on;
    logic [PIXEL_BITS-1:0] best_diff;
    bit                    best_valid;
    logic [SENS_W-1:0]     best_srow, best_scol;

    laser_spot_difference_peak_height u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: ends the run when no transaction of any channel happens for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Height of the peak row: numerator / divisor in Q16.16, saturated.
    function automatic logic signed [WORD_W-1:0] spot_height(input logic [SENS_W-1:0] srow);
        longint num, den, quo;
        num = longint'($signed(regs_mirror.height_numerator));
        den = (longint'(regs_mirror.optical_center_row) - longint'(srow))
              * longint'($signed(regs_mirror.tan_alpha))
              + longint'($signed(regs_mirror.x_term));
        if (den == 0) begin
            return (num >= 0) ? HEIGHT_MAX : HEIGHT_MIN;
        end
        quo = (num * 65536) / den;
        if (quo > longint'(HEIGHT_MAX)) begin
            return HEIGHT_MAX;
        end
        if (quo < longint'(HEIGHT_MIN)) begin
            return HEIGHT_MIN;
        end
        return quo[WORD_W-1:0];
    endfunction

    task automatic restart_walk();
        walk_row   = '0;
        walk_col   = '0;
        best_diff  = '0;
        best_valid = 1'b0;
        best_srow  = '0;
        best_scol  = '0;
    endtask

    // Advances the mirror by one pixel and works out the result it causes, if any.
    task automatic track_spot(input t_pixel_in px, output bit emits, output t_result r);
        int                    rows, cols, addr;
        bit                    row_end, frame_end;
        logic [PIXEL_BITS-1:0] diff, stored;
        rows = (regs_mirror.row_count == 0) ? 1 : int'(regs_mirror.row_count);
        cols = (regs_mirror.col_count == 0) ? 1 : int'(regs_mirror.col_count);
        if (px.first_of_pair) begin
            laser_on = 1'b0;
            restart_walk();
        end
        addr      = (int'(walk_row) * cols + int'(walk_col)) % STORE_DEPTH;
        row_end   = int'(walk_col) + 1 >= cols;
        frame_end = row_end && (int'(walk_row) + 1 >= rows);
        r     = '0;
        emits = 1'b0;
        if (!laser_on) begin
            dark_frame[addr] = px.pixel_value;
        end else begin
            stored = dark_frame[addr];
            diff = (stored > px.pixel_value) ? stored - px.pixel_value
                                             : px.pixel_value - stored;
            if (!best_valid || diff > best_diff) begin
                best_diff  = diff;
                best_valid = 1'b1;
                best_srow  = walk_row + regs_mirror.row_start;
                best_scol  = walk_col + regs_mirror.col_start;
            end
            r.diff_value = diff;
            if (frame_end) begin
                r.peak_row   = best_srow;
                r.peak_col   = best_scol;
                r.peak_value = best_diff;
                r.height     = spot_height(best_srow);
                r.pair_done  = 1'b1;
            end
            emits = 1'b1;
        end
        // Step the walk to the next pixel of the window.
        if (frame_end) begin
            laser_on = !laser_on;
            restart_walk();
        end else if (row_end) begin
            walk_col = '0;
            walk_row = walk_row + 1'b1;
        end else begin
            walk_col = walk_col + 1'b1;
        end
    endtask

    // Waits until every expected result is out and the pipeline has drained.
    task automatic settle();
        i_valid <= 1'b0;
        while (spot_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; valid is lowered by the next pixel transaction.
    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROW_START: regs_mirror.row_start          = data[CNT_W-1:0];
            CFG_ROW_COUNT: regs_mirror.row_count          = data[CNT_W-1:0];
            CFG_COL_START: regs_mirror.col_start          = data[CNT_W-1:0];
            CFG_COL_COUNT: regs_mirror.col_count          = data[CNT_W-1:0];
            CFG_OPT_ROW:   regs_mirror.optical_center_row = data[SENS_W-1:0];
            CFG_TAN_ALPHA: regs_mirror.tan_alpha          = data;
            CFG_X_TERM:    regs_mirror.x_term             = data;
            CFG_NUMERATOR: regs_mirror.height_numerator   = data;
            default: ;
        endcase
    endtask

    // One pixel transaction; the expectation is queued before the pixel is offered.
    task automatic send_pixel(input t_pixel_in px, input bit typed, input t_result want);
        bit      emits;
        t_result r;
        int      gap;
        i_cfg_valid <= 1'b0;
        track_spot(px, emits, r);
        if (emits) begin
            spot_results_due.push_back(typed ? want : r);
        end
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic plan_reg(input t_cfg_idx idx, input logic [31:0] data);
        t_plan_row row;
        row = '{is_reg: 1'b1, reg_idx: idx, reg_data: data, px: '0, typed: 1'b0, want: '0};
        directed_plan.push_back(row);
    endtask

    task automatic plan_pixel(input logic [PIXEL_BITS-1:0] pix, input bit first);
        t_plan_row row;
        row = '{is_reg: 1'b0, reg_idx: CFG_ROW_START, reg_data: '0,
                px: '{pixel_value: pix, first_of_pair: first}, typed: 1'b0, want: '0};
        directed_plan.push_back(row);
    endtask

    task automatic plan_result(input logic [PIXEL_BITS-1:0] pix, input bit first,
                               input logic [PIXEL_BITS-1:0] diff, input logic [SENS_W-1:0] prow,
                               input logic [SENS_W-1:0] pcol, input logic [PIXEL_BITS-1:0] pval,
                               input logic signed [WORD_W-1:0] height, input bit done);
        t_plan_row row;
        row = '{is_reg: 1'b0, reg_idx: CFG_ROW_START, reg_data: '0,
                px: '{pixel_value: pix, first_of_pair: first}, typed: 1'b1,
                want: '{diff_value: diff, peak_row: prow, peak_col: pcol, peak_value: pval,
                        height: height, pair_done: done}};
        directed_plan.push_back(row);
    endtask

    // Q16.16 value biased towards zero, the extremes and small magnitudes.
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'($urandom_range(0, 131072)) - 32'd65536;
            default: return $urandom();
        endcase
    endfunction

    // One random window: registers, then whole pairs; noisy ones add extra pixels and restart marks.
    task automatic run_window(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols,
                              input int pairs, input bit noisy, output int sent);
        t_pixel_in   px;
        logic [31:0] junk, tan, xterm;
        int          area, total;
        settle();
        junk  = ($urandom_range(0, 1) != 0) ? $urandom() : 32'd0;
        tan   = pick_q16();
        xterm = pick_q16();
        if ($urandom_range(0, 5) == 0) begin
            tan   = '0;
            xterm = '0;
        end
        cfg_write(CFG_ROW_START, {junk[31:CNT_W], CNT_W'($urandom_range(0, 127))});
        cfg_write(CFG_ROW_COUNT, {junk[31:CNT_W], rows});
        cfg_write(CFG_COL_START, {junk[31:CNT_W], CNT_W'($urandom_range(0, 127))});
        cfg_write(CFG_COL_COUNT, {junk[31:CNT_W], cols});
        cfg_write(CFG_OPT_ROW, {junk[31:SENS_W], SENS_W'($urandom_range(0, 255))});
        cfg_write(CFG_TAN_ALPHA, tan);
        cfg_write(CFG_X_TERM, xterm);
        cfg_write(CFG_NUMERATOR, pick_q16());
        no_idle = ($urandom_range(0, 3) == 0);
        area  = ((rows == 0) ? 1 : int'(rows)) * ((cols == 0) ? 1 : int'(cols));
        total = pairs * 2 * area + (noisy ? $urandom_range(0, area) : 0);
        for (int k = 0; k < total; k++) begin
            case ($urandom_range(0, 7))
                0:       px.pixel_value = '0;
                1:       px.pixel_value = '1;
                default: px.pixel_value = PIXEL_BITS'($urandom());
            endcase
            px.first_of_pair = (k == 0) || (noisy && $urandom_range(0, 39) == 0);
            send_pixel(px, 1'b0, '0);
        end
        sent = total;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stalls, each accepted result checked against the oldest expectation.
    initial begin : result_sink
        t_result got, want;
        int      stall;
        wait (i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = o_result;
            if (spot_results_due.size() == 0) begin
                $error("result transaction with no result expected");
                mismatches++;
            end else begin
                want = spot_results_due.pop_front();
                check_field("diff_value", want.diff_value, got.diff_value);
                check_field("peak_row", want.peak_row, got.peak_row);
                check_field("peak_col", want.peak_col, got.peak_col);
                check_field("peak_value", want.peak_value, got.peak_value);
                check_field("height", $signed(want.height), $signed(got.height));
                check_field("pair_done", want.pair_done, got.pair_done);
            end
        end
    end

    // Stimulus: reset, directed table, random windows, then the final verdict.
    initial begin : stimulus
        int sent, small_items;
        small_items = 0;
        regs_mirror = '{row_start: ROW_START_RST, row_count: ROW_COUNT_RST,
                        col_start: COL_START_RST, col_count: COL_COUNT_RST,
                        optical_center_row: OPT_ROW_RST, tan_alpha: '0, x_term: '0,
                        height_numerator: '0};
        laser_on = 1'b0;
        restart_walk();

        // One row by two columns with flat height terms, so the divisor is zero.
        plan_reg(CFG_ROW_START, 0);
        plan_reg(CFG_ROW_COUNT, 1);
        plan_reg(CFG_COL_START, 0);
        plan_reg(CFG_COL_COUNT, 2);
        plan_reg(CFG_OPT_ROW, 0);
        plan_reg(CFG_TAN_ALPHA, 0);
        plan_reg(CFG_X_TERM, 0);
        plan_reg(CFG_NUMERATOR, 0);
        plan_pixel(0, 1'b1);
        plan_pixel(4095, 1'b0);
        plan_result(4095, 1'b0, 4095, 0, 0, 0, 0, 1'b0);
        plan_result(4095, 1'b0, 0, 0, 0, 4095, HEIGHT_MAX, 1'b1);
        // The next pair follows without a mark; of two equal differences the first is kept.
        plan_pixel(100, 1'b0);
        plan_pixel(100, 1'b0);
        plan_result(110, 1'b0, 10, 0, 0, 0, 0, 1'b0);
        plan_result(90, 1'b0, 10, 0, 0, 10, HEIGHT_MAX, 1'b1);
        // Restart mark in the middle of the laser-on frame.
        plan_pixel(1, 1'b1);
        plan_pixel(2, 1'b0);
        plan_pixel(3, 1'b0);
        plan_pixel(7, 1'b1);
        plan_pixel(8, 1'b0);
        plan_pixel(8, 1'b0);
        plan_pixel(7, 1'b0);
        // Zero column count acts as one; the peak row cancels a non-zero tan_alpha.
        plan_reg(CFG_ROW_START, 127);
        plan_reg(CFG_COL_START, 127);
        plan_reg(CFG_COL_COUNT, 0);
        plan_reg(CFG_OPT_ROW, 127);
        plan_reg(CFG_TAN_ALPHA, 32'h0001_8000);
        plan_reg(CFG_NUMERATOR, 32'h0003_0000);
        plan_pixel(9, 1'b0);
        plan_result(0, 1'b0, 9, 127, 127, 9, HEIGHT_MAX, 1'b1);
        // Negative numerator over a zero divisor.
        plan_reg(CFG_NUMERATOR, 32'h8000_0000);
        plan_pixel(9, 1'b1);
        plan_result(0, 1'b0, 9, 127, 127, 9, HEIGHT_MIN, 1'b1);
        // A divisor of one LSB makes the quotient saturate both ways.
        plan_reg(CFG_OPT_ROW, 0);
        plan_reg(CFG_TAN_ALPHA, 0);
        plan_reg(CFG_X_TERM, 1);
        plan_reg(CFG_NUMERATOR, 32'h7FFF_FFFF);
        plan_pixel(4095, 1'b1);
        plan_result(0, 1'b0, 4095, 127, 127, 4095, HEIGHT_MAX, 1'b1);
        plan_reg(CFG_NUMERATOR, 32'h8000_0000);
        plan_pixel(0, 1'b1);
        plan_result(4095, 1'b0, 4095, 127, 127, 4095, HEIGHT_MIN, 1'b1);
        // An ordinary height over a two-pixel window.
        plan_reg(CFG_ROW_START, 3);
        plan_reg(CFG_COL_START, 4);
        plan_reg(CFG_COL_COUNT, 2);
        plan_reg(CFG_OPT_ROW, 200);
        plan_reg(CFG_TAN_ALPHA, 32'hFFFF_0000);
        plan_reg(CFG_X_TERM, 32'h0064_0000);
        plan_reg(CFG_NUMERATOR, 32'h0010_0000);
        plan_pixel(10, 1'b1);
        plan_pixel(20, 1'b0);
        plan_pixel(12, 1'b0);
        plan_pixel(60, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; registers are only written once the block is idle.
        foreach (directed_plan[k]) begin
            if (directed_plan[k].is_reg) begin
                if (k == 0 || !directed_plan[k-1].is_reg) begin
                    settle();
                end
                cfg_write(directed_plan[k].reg_idx, directed_plan[k].reg_data);
            end else begin
                send_pixel(directed_plan[k].px, directed_plan[k].typed, directed_plan[k].want);
            end
        end

        // Tallest window: a row count above the nominal range and a zero column count.
        run_window(7'd127, 7'd0, 1, 1'b0, sent);
        // Mostly small windows with random contents and occasional restart marks.
        while (small_items < SMALL_ITEMS) begin
            run_window(CNT_W'($urandom_range(0, 4)), CNT_W'($urandom_range(0, 6)),
                       $urandom_range(1, 2), 1'b1, sent);
            small_items += sent;
        end

        settle();
        if (mismatches == 0 && spot_results_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
